@@ rtl/b64sc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared types and character mapping functions of the base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

    localparam logic [7:0] PadChar = 8'h3d;
    localparam logic [7:0] PlusChar = 8'h2b;
    localparam logic [7:0] SlashChar = 8'h2f;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // result group of one input transaction, slot 0 goes out first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } t_group;

    function automatic logic [7:0] char_of(input logic [5:0] s);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, s};
        if (s < 6'd26) begin
            c = w + 8'd65;
        end else if (s < 6'd52) begin
            c = w + 8'd71;
        end else if (s < 6'd62) begin
            c = w - 8'd4;
        end else if (s == 6'd62) begin
            c = PlusChar;
        end else begin
            c = SlashChar;
        end
        return c;
    endfunction

    // bit 6 set marks a character outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        if (c >= 8'h41 && c <= 8'h5a) begin
            v = 7'(c - 8'd65);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            v = 7'(c - 8'd71);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 7'(c + 8'd4);
        end else if (c == PlusChar) begin
            v = 7'd62;
        end else if (c == SlashChar) begin
            v = 7'd63;
        end else begin
            v = 7'd64;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/b64sc_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_step
// Input register, group state and encode/decode logic; produces one result
// group per transaction that has results.
// ----------------------------------------------------------------------------
module b64sc_step
    import b64sc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_wr_en,
    input  wire logic     i_cfg_wr_data,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_grp_valid,
    output t_group        o_grp,
    input  wire logic     i_grp_ready
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_dir;
    logic [23:0] r_buf;
    logic [1:0]  r_cnt;
    logic        r_stop;

    logic [23:0] n_buf;
    logic [1:0]  n_cnt;
    logic        n_stop;
    logic        grp_push;
    t_group      grp;
    logic        advance;

    logic [23:0] e_buf;
    logic [2:0]  e_cnt;
    logic [23:0] d_buf;
    logic [2:0]  d_cnt;
    logic [23:0] al;
    logic [6:0]  sv;

    assign advance     = r_in_valid && (i_grp_ready || !grp_push);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_grp_valid = r_in_valid && grp_push;
    assign o_grp       = grp;

    always_comb begin
        n_buf    = r_buf;
        n_cnt    = r_cnt;
        n_stop   = r_stop;
        grp_push = 1'b0;
        grp      = '0;
        e_buf    = {r_buf[15:0], r_in.in_byte};
        e_cnt    = {1'b0, r_cnt} + 3'd1;
        d_buf    = r_buf;
        d_cnt    = {1'b0, r_cnt};
        al       = '0;
        sv       = sextet_of(r_in.in_byte);
        if (!r_dir) begin
            if (e_cnt == 3'd3) begin
                grp.bytes[0] = char_of(e_buf[23:18]);
                grp.bytes[1] = char_of(e_buf[17:12]);
                grp.bytes[2] = char_of(e_buf[11:6]);
                grp.bytes[3] = char_of(e_buf[5:0]);
                grp.last_idx = 2'd3;
                grp_push     = 1'b1;
                e_buf        = '0;
                e_cnt        = '0;
            end
            if (r_in.in_end && e_cnt != 3'd0) begin
                al = (e_cnt == 3'd1) ? {e_buf[7:0], 16'h0000} : {e_buf[15:0], 8'h00};
                grp.bytes[0] = char_of(al[23:18]);
                grp.bytes[1] = char_of(al[17:12]);
                grp.bytes[2] = (e_cnt == 3'd2) ? char_of(al[11:6]) : PadChar;
                grp.bytes[3] = PadChar;
                grp.last_idx = 2'd3;
                grp_push     = 1'b1;
            end
            n_buf = e_buf;
            n_cnt = e_cnt[1:0];
        end else begin
            if (!r_stop) begin
                if (sv[6]) begin
                    n_stop = 1'b1;
                end else begin
                    d_buf = {r_buf[17:0], sv[5:0]};
                    d_cnt = d_cnt + 3'd1;
                    if (d_cnt == 3'd4) begin
                        grp.bytes[0] = d_buf[23:16];
                        grp.bytes[1] = d_buf[15:8];
                        grp.bytes[2] = d_buf[7:0];
                        grp.last_idx = 2'd2;
                        grp_push     = 1'b1;
                        d_buf        = '0;
                        d_cnt        = '0;
                    end
                end
            end
            if (r_in.in_end && d_cnt >= 3'd2) begin
                al = (d_cnt == 3'd2) ? {d_buf[11:0], 12'h000} : {d_buf[17:0], 6'h00};
                grp.bytes[0] = al[23:16];
                grp.bytes[1] = al[15:8];
                grp.last_idx = (d_cnt == 3'd2) ? 2'd0 : 2'd1;
                grp_push     = 1'b1;
            end
            n_buf = d_buf;
            n_cnt = d_cnt[1:0];
        end
        if (r_in.in_end) begin
            n_buf  = '0;
            n_cnt  = '0;
            n_stop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_dir      <= 1'b0;
            r_buf      <= '0;
            r_cnt      <= '0;
            r_stop     <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_wr_en) begin
                r_dir  <= i_cfg_wr_data;
                r_buf  <= '0;
                r_cnt  <= '0;
                r_stop <= 1'b0;
            end else if (advance) begin
                r_buf  <= n_buf;
                r_cnt  <= n_cnt;
                r_stop <= n_stop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

endmodule
`default_nettype wire

@@ rtl/b64sc_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_emit
// Result group register; sends the group out one byte per transaction.
// ----------------------------------------------------------------------------
module b64sc_emit
    import b64sc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_grp_valid,
    input  wire t_group i_grp,
    output logic        o_grp_ready,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output t_out_item   o_out_item
);

    logic       r_valid;
    t_group     r_grp;
    logic [1:0] r_idx;
    logic       last;

    assign last                = (r_idx == r_grp.last_idx);
    assign o_grp_ready         = !r_valid || (i_out_ready && last);
    assign o_out_valid         = r_valid;
    assign o_out_item.out_byte = r_grp.bytes[r_idx];
    assign o_out_item.out_last = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_grp_ready) begin
            r_valid <= i_grp_valid;
            r_idx   <= '0;
        end else if (i_out_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_grp_ready && i_grp_valid) begin
            r_grp <= i_grp;
        end
    end

endmodule
`default_nettype wire

@@ rtl/base64_stream_codec.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder/decoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// One byte is taken per transaction; in_end flushes and clears the group.
// Direction 0 encodes, 1 decodes; a direction write also clears the group.
// An input byte passes an input register and a result register before its
// first result can be taken. A byte with results holds the output port for
// one transaction per result (up to four), and a final partial encode group
// sends four characters with padding.
// Decoding yields three bytes per four characters and keeps up with one
// character per cycle while the output does not stall. The single byte wide
// output port sets the encode rate.
module base64_stream_codec
    import b64sc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_wr_en,
    input  wire logic     i_cfg_wr_data,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_item
);

    logic   grp_valid;
    logic   grp_ready;
    t_group grp;

    b64sc_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .o_grp_valid   (grp_valid),
        .o_grp         (grp),
        .i_grp_ready   (grp_ready)
    );

    b64sc_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (grp_valid),
        .i_grp       (grp),
        .o_grp_ready (grp_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base64_stream_codec. A short table of strings
// walks the edge cases of both directions, then random strings run through
// several idle and stall mixes, one with a long output hold-off. Every output
// transaction is scored against the table (typed rows) or a bench codec model.
// ----------------------------------------------------------------------------
module tb;
    import b64sc_pkg::*;

    typedef enum logic {DIR_ENCODE = 1'b0, DIR_DECODE = 1'b1} t_codec_dir;

    typedef struct packed {
        t_codec_dir  dir;
        logic [7:0]  ch;
        logic        fin;
        logic        typed;
        logic [2:0]  nexp;
        logic [31:0] exp_syms;
    } t_stim_row;

    localparam int NUM_ROWS = 25;
    localparam int SEG_ITEMS = 31;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 8;

    // typed rows carry their outputs right aligned, first output in the high byte
    localparam t_stim_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{DIR_ENCODE, 8'h00, 1'b0, 1'b1, 3'd0, 32'd0},
        '{DIR_ENCODE, 8'h00, 1'b0, 1'b1, 3'd0, 32'd0},
        '{DIR_ENCODE, 8'h00, 1'b1, 1'b1, 3'd4, "AAAA"},
        '{DIR_ENCODE, 8'hff, 1'b0, 1'b1, 3'd0, 32'd0},
        '{DIR_ENCODE, 8'hff, 1'b0, 1'b1, 3'd0, 32'd0},
        '{DIR_ENCODE, 8'hff, 1'b1, 1'b1, 3'd4, "////"},
        '{DIR_ENCODE, "M",   1'b1, 1'b1, 3'd4, "TQ=="},
        '{DIR_ENCODE, "M",   1'b0, 1'b1, 3'd0, 32'd0},
        '{DIR_ENCODE, "a",   1'b1, 1'b1, 3'd4, "TWE="},
        '{DIR_ENCODE, "M",   1'b0, 1'b0, 3'd0, 32'd0},
        '{DIR_ENCODE, "a",   1'b0, 1'b0, 3'd0, 32'd0},
        '{DIR_ENCODE, "n",   1'b0, 1'b1, 3'd4, "TWFu"},
        '{DIR_DECODE, "T",   1'b0, 1'b1, 3'd0, 32'd0},
        '{DIR_DECODE, "W",   1'b0, 1'b1, 3'd0, 32'd0},
        '{DIR_DECODE, "F",   1'b0, 1'b0, 3'd0, 32'd0},
        '{DIR_DECODE, "u",   1'b0, 1'b1, 3'd3, "Man"},
        '{DIR_DECODE, "T",   1'b0, 1'b0, 3'd0, 32'd0},
        '{DIR_DECODE, "Q",   1'b0, 1'b0, 3'd0, 32'd0},
        '{DIR_DECODE, "=",   1'b0, 1'b1, 3'd0, 32'd0},
        '{DIR_DECODE, "A",   1'b1, 1'b1, 3'd1, "M"},
        '{DIR_DECODE, "Q",   1'b1, 1'b1, 3'd0, 32'd0},
        '{DIR_DECODE, "+",   1'b0, 1'b0, 3'd0, 32'd0},
        '{DIR_DECODE, "/",   1'b0, 1'b0, 3'd0, 32'd0},
        '{DIR_DECODE, 8'h00, 1'b0, 1'b1, 3'd0, 32'd0},
        '{DIR_DECODE, 8'hff, 1'b1, 1'b1, 3'd1, 32'h0000_00fb}
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    t_codec_dir  cur_dir = DIR_ENCODE;
    logic [23:0] group_bits = '0;
    int          group_fill = 0;
    logic        decode_halted = 1'b0;
    logic [7:0]  step_syms [4];
    int          step_n = 0;

    t_out_item awaited_syms [$];
    int        mismatches = 0;
    int        holds_asked = 0;
    int        holds_served = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    base64_stream_codec dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_item     (in_item),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_item    (out_item)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        if (s < 6'd26) begin
            return "A" + 8'(s);
        end else if (s < 6'd52) begin
            return "a" + 8'(s) - 8'd26;
        end else if (s < 6'd62) begin
            return "0" + 8'(s) - 8'd52;
        end else if (s == 6'd62) begin
            return PlusChar;
        end
        return SlashChar;
    endfunction

    // -1 for anything outside the alphabet, pad included
    function automatic int sextet_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return int'(c) - int'("A");
        end else if (c >= "a" && c <= "z") begin
            return int'(c) - int'("a") + 26;
        end else if (c >= "0" && c <= "9") begin
            return int'(c) - int'("0") + 52;
        end else if (c == PlusChar) begin
            return 62;
        end else if (c == SlashChar) begin
            return 63;
        end
        return -1;
    endfunction

    task automatic clear_group();
        group_bits = '0;
        group_fill = 0;
        decode_halted = 1'b0;
    endtask

    task automatic emit_sym(input logic [7:0] s);
        step_syms[step_n] = s;
        step_n++;
    endtask

    task automatic codec_step(input t_in_item it);
        int          v;
        logic [23:0] aligned;
        step_n = 0;
        if (cur_dir == DIR_ENCODE) begin
            group_bits = {group_bits[15:0], it.in_byte};
            group_fill++;
            if (group_fill == 3) begin
                for (int k = 0; k < 4; k++) emit_sym(sextet_char(group_bits[18 - 6 * k +: 6]));
                group_bits = '0;
                group_fill = 0;
            end
            if (it.in_end && group_fill > 0) begin
                aligned = group_bits << (8 * (3 - group_fill));
                for (int k = 0; k < 4; k++) begin
                    if (k <= group_fill) begin
                        emit_sym(sextet_char(aligned[18 - 6 * k +: 6]));
                    end else begin
                        emit_sym(PadChar);
                    end
                end
            end
        end else begin
            if (!decode_halted) begin
                v = sextet_value(it.in_byte);
                if (v < 0) begin
                    decode_halted = 1'b1;
                end else begin
                    group_bits = {group_bits[17:0], 6'(v)};
                    group_fill++;
                    if (group_fill == 4) begin
                        for (int k = 0; k < 3; k++) emit_sym(group_bits[16 - 8 * k +: 8]);
                        group_bits = '0;
                        group_fill = 0;
                    end
                end
            end
            if (it.in_end && group_fill >= 2) begin
                aligned = group_bits << (6 * (4 - group_fill));
                for (int k = 0; k < group_fill - 1; k++) emit_sym(aligned[16 - 8 * k +: 8]);
            end
        end
        if (it.in_end) begin
            clear_group();
        end
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input t_in_item it, input logic typed, input logic [2:0] nexp,
                             input logic [31:0] exp_syms);
        t_out_item sym;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        codec_step(it);
        if (typed) begin
            for (int j = 0; j < nexp; j++) begin
                sym.out_byte = exp_syms[8 * (nexp - 1 - j) +: 8];
                sym.out_last = (j == nexp - 1);
                awaited_syms.push_back(sym);
            end
        end else begin
            for (int j = 0; j < step_n; j++) begin
                sym.out_byte = step_syms[j];
                sym.out_last = (j == step_n - 1);
                awaited_syms.push_back(sym);
            end
        end
        @(negedge clk);
    endtask

    task automatic settle();
        while (awaited_syms.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input t_codec_dir d);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= d;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_dir = d;
        clear_group();
    endtask

    always @(posedge clk) begin : out_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_syms.size() == 0) begin
                $error("out_item: unexpected transaction, got %02h last %0b",
                       out_item.out_byte, out_item.out_last);
                mismatches++;
            end else begin
                want = awaited_syms.pop_front();
                if (out_item.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, out_item.out_byte);
                    mismatches++;
                end
                if (out_item.out_last !== want.out_last) begin
                    $error("out_last: expected %0b, got %0b", want.out_last, out_item.out_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin : out_side
        forever begin
            @(negedge clk);
            if (holds_asked != holds_served) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                holds_served++;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        t_in_item  it;
        t_in_item  word_q [$];
        t_stim_row row;
        int        count;
        int        len;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.dir != cur_dir) begin
                in_valid <= 1'b0;
                settle();
                cfg_write(row.dir);
            end
            it.in_byte = row.ch;
            it.in_end = row.fin;
            send_item(it, row.typed, row.nexp, row.exp_syms);
        end

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 76;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 76;
                end
                3: begin
                    send_idle_pct = 33;
                    recv_stall_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int s = 0; s < 2; s++) begin
                // a segment may stop mid-string, the direction write clears it
                in_valid <= 1'b0;
                settle();
                cfg_write(s == 0 ? DIR_ENCODE : DIR_DECODE);
                if (ph == 4 && s == 0) begin
                    holds_asked++;
                end
                count = 0;
                while (count < SEG_ITEMS) begin
                    word_q.delete();
                    if (cur_dir == DIR_ENCODE) begin
                        len = $urandom_range(1, 8);
                        repeat (len) word_q.push_back({8'($urandom_range(0, 255)), 1'b0});
                    end else if ($urandom_range(0, 9) < 7) begin
                        len = $urandom_range(1, 10);
                        repeat (len) begin
                            word_q.push_back({sextet_char(6'($urandom_range(0, 63))), 1'b0});
                        end
                        if (len % 4 != 0 && $urandom_range(0, 1) == 1) begin
                            repeat (4 - len % 4) word_q.push_back({PadChar, 1'b0});
                        end
                        if ($urandom_range(0, 3) == 0) begin
                            repeat ($urandom_range(1, 2)) begin
                                word_q.push_back({8'($urandom_range(0, 255)), 1'b0});
                            end
                        end
                    end else begin
                        repeat ($urandom_range(1, 6)) begin
                            word_q.push_back({8'($urandom_range(0, 255)), 1'b0});
                        end
                    end
                    word_q[word_q.size() - 1].in_end = 1'b1;
                    foreach (word_q[k]) begin
                        if (count >= SEG_ITEMS) break;
                        send_item(word_q[k], 1'b0, 3'd0, 32'd0);
                        count++;
                    end
                end
            end
        end

        in_valid <= 1'b0;
        settle();
        if (mismatches == 0 && awaited_syms.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/b64sc_pkg.sv
rtl/b64sc_step.sv
rtl/b64sc_emit.sv
rtl/base64_stream_codec.sv
sim/tb.sv
